>>> hw/rtl/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types, character codes and helper functions for the expression
// token scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

    // Width of the position and length counters, 8 to 32.
    localparam int POSITION_WIDTH = 16;

    // Width of the position and length fields on the result ports.
    localparam int FIELD_W = 16;

    // Counters saturate at the smaller of 2^POSITION_WIDTH - 1 and 65535,
    // so they never need more bits than the result field.
    localparam int CNT_W = (POSITION_WIDTH < FIELD_W) ? POSITION_WIDTH : FIELD_W;

    // Token queue between the scanner front and the result port.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CNT_W-1:0] count_t;

    typedef enum logic [3:0] {
        KIND_PLUS    = 4'd0,
        KIND_MINUS   = 4'd1,
        KIND_STAR    = 4'd2,
        KIND_SLASH   = 4'd3,
        KIND_CARET   = 4'd4,
        KIND_LPAREN  = 4'd5,
        KIND_RPAREN  = 4'd6,
        KIND_LBRACE  = 4'd7,
        KIND_RBRACE  = 4'd8,
        KIND_COMMA   = 4'd9,
        KIND_EOF     = 4'd10,
        KIND_ILLEGAL = 4'd11,
        KIND_IDENT   = 4'd12,
        KIND_NUMBER  = 4'd13
    } kind_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         ch;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic               last;
    } token_t;

    // Tokens produced by one input word: count is 0, 1 or 2, first goes first.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } tok_pair_t;

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)
            || c == CH_UNDER;
    endfunction

    function automatic logic is_num_char(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || c == CH_DOT;
    endfunction

    function automatic logic is_space_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_single_char(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH
            || c == CH_CARET || c == CH_LPAREN || c == CH_RPAREN
            || c == CH_LBRACE || c == CH_RBRACE || c == CH_COMMA;
    endfunction

    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_CARET:  k = KIND_CARET;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_COMMA:  k = KIND_COMMA;
            default:   k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

    // Saturate at all ones of the counter width.
    function automatic count_t sat_inc(input count_t v);
        return (v == {CNT_W{1'b1}}) ? v : count_t'(v + count_t'(1));
    endfunction

endpackage

>>> hw/rtl/ets_front.sv
// ----------------------------------------------------------------------------
// ets_front
// Scanner front: classifies each input word, tracks the open run and the
// byte position, and hands zero, one or two tokens to the token queue.
// ----------------------------------------------------------------------------
module ets_front
    import ets_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] input_byte,
    output tok_pair_t  tokens
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } mode_t;

    mode_t  mode_reg, mode_next;
    count_t run_start_reg, run_start_next;
    count_t run_len_reg, run_len_next;
    count_t pos_reg, pos_next;

    logic   in_run;
    logic   run_cont;
    logic   is_word;
    logic   is_num;
    logic   is_single;
    logic   own_valid;
    token_t run_tok;
    token_t own_tok;

    always_comb
    begin
        is_word   = is_word_char(input_byte);
        is_num    = is_num_char(input_byte);
        is_single = is_single_char(input_byte);
        in_run    = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER);
        run_cont  = (mode_reg == MODE_IDENT && is_word)
                 || (mode_reg == MODE_NUMBER && is_num);

        // Token of this word itself, if it makes one.
        own_valid     = !run_cont && (input_byte == CH_NUL || is_single
                        || (!is_word && !is_num && !is_space_char(input_byte)));
        own_tok.ch    = input_byte;
        own_tok.start = FIELD_W'(pos_reg);
        own_tok.len   = FIELD_W'(1);
        own_tok.last  = 1'b1;
        if (input_byte == CH_NUL)
        begin
            own_tok.kind = KIND_EOF;
            own_tok.len  = '0;
        end
        else
        begin
            own_tok.kind = single_kind(input_byte);
        end

        // Token of the run that this word closes.
        run_tok.kind  = (mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
        run_tok.ch    = '0;
        run_tok.start = FIELD_W'(run_start_reg);
        run_tok.len   = FIELD_W'(run_len_reg);
        run_tok.last  = !own_valid;

        tokens.second = own_tok;
        if (in_run && !run_cont)
        begin
            tokens.first = run_tok;
            tokens.count = own_valid ? 2'd2 : 2'd1;
        end
        else
        begin
            tokens.first = own_tok;
            tokens.count = own_valid ? 2'd1 : 2'd0;
        end
        if (!accept)
        begin
            tokens.count = 2'd0;
        end

        mode_next      = mode_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        pos_next       = pos_reg;
        if (accept)
        begin
            if (run_cont)
            begin
                run_len_next = sat_inc(run_len_reg);
                pos_next     = sat_inc(pos_reg);
            end
            else
            begin
                mode_next = MODE_IDLE;
                if (input_byte == CH_NUL)
                begin
                    pos_next = '0;
                end
                else
                begin
                    // Open a new run on a word or number character.
                    if (!is_single && (is_word || is_num))
                    begin
                        mode_next      = is_word ? MODE_IDENT : MODE_NUMBER;
                        run_start_next = pos_reg;
                        run_len_next   = count_t'(1);
                    end
                    pos_next = sat_inc(pos_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

>>> hw/rtl/ets_token_queue.sv
// ----------------------------------------------------------------------------
// ets_token_queue
// Token queue: takes up to two tokens a cycle, gives out one a cycle in order.
// ----------------------------------------------------------------------------
module ets_token_queue
    import ets_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tok_pair_t wr,
    output logic      no_room,
    output logic      empty,
    input  logic      pop,
    output token_t    head
);

    token_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;
    logic [QPTR_W-1:0]   wr_ptr_plus1;

    always_comb
    begin
        empty        = (count_reg == '0);
        // Hold the input off unless two entries are free.
        no_room      = (count_reg > QCNT_W'(QUEUE_DEPTH - 2));
        do_pop       = pop && !empty;
        head         = mem[rd_ptr_reg];
        wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + QPTR_W'(wr.count);
        rd_ptr_next  = rd_ptr_reg + QPTR_W'(do_pop);
        count_next   = count_reg + QCNT_W'(wr.count) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr.first;
        end
        if (wr.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= wr.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/expression_token_scanner.sv
// ----------------------------------------------------------------------------
// expression_token_scanner
// Splits an arithmetic-expression text, one byte per word, into tokens.
// ----------------------------------------------------------------------------
// Push one text byte per cycle; a zero byte ends the text, closes any open
// identifier or number run, emits an EOF token and sets the position back to
// zero. The scanner front classifies each byte and writes zero, one or two
// tokens (a closed run, then the byte's own token) into an 8-entry token
// queue; the result side drains it one token per cycle while pop is high and
// it is not empty, and tokens wait there until popped. Since a byte can add
// two tokens, full rises whenever fewer than two queue entries are free; the
// block takes a byte whenever full is low, and holding pop high does not keep
// full low. last_of_run marks the final token of each byte. Start position
// and length saturate at 65535.
// ----------------------------------------------------------------------------
module expression_token_scanner
    import ets_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // Text byte side
    input  logic               push,
    output logic               full,
    input  logic [7:0]         input_byte,

    // Token side
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         token_kind,
    output logic [7:0]         token_char,
    output logic [FIELD_W-1:0] start_position,
    output logic [FIELD_W-1:0] token_length,
    output logic               last_of_run
);

    tok_pair_t tokens;
    token_t    head;
    logic      accept;

    // Take a byte only when the queue can absorb its worst case of two tokens.
    assign accept = push && !full;

    ets_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .input_byte (input_byte),
        .tokens     (tokens)
    );

    ets_token_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tokens),
        .no_room (full),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    // Drive the oldest waiting token onto the result ports.
    assign token_kind     = head.kind;
    assign token_char     = head.ch;
    assign start_position = head.start;
    assign token_length   = head.len;
    assign last_of_run    = head.last;

endmodule
